// ===== rtl/lrt_pkg.sv =====
// Shared types, constants and lookup tables of the logistic regression trainer.
package lrt_pkg;

    localparam int NFEAT_MAX = 8;
    localparam int FEAT_W    = 32;
    localparam int IDX_W     = 3;
    localparam int ACC_W     = 56;
    localparam int LR_W      = 31;
    localparam int LIM_W     = 16;
    localparam int DCNT_W    = 6;

    localparam logic [LR_W-1:0]  LR_RESET  = 31'd6554;
    localparam logic [LIM_W-1:0] LIM_RESET = 16'd10;
    localparam logic [19:0]      LN2_Q16   = 20'd45426;

    localparam logic CFG_LR    = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef logic [NFEAT_MAX-1:0][FEAT_W-1:0] t_vec;

    typedef enum logic [3:0] {
        S_IDLE, S_DOT_MUL, S_DOT_ACC, S_SIG, S_LOG, S_COST, S_GRAD_MUL, S_GRAD_ACC,
        S_DIV_GO, S_DIV_WAIT, S_UPD_MUL, S_UPD_ACC, S_MEAN_GO, S_MEAN_WAIT, S_LOAD
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAPTURE, OP_DOT_MUL, OP_DOT_ACC, OP_SIG, OP_LOG, OP_COST,
        OP_GRAD_MUL, OP_GRAD_ACC, OP_DIV_GO, OP_DIV_WAIT, OP_UPD_MUL, OP_UPD_ACC,
        OP_MEAN_GO, OP_MEAN_WAIT, OP_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic k_clr;
        logic k_inc;
    } t_cmd;

    typedef struct packed {
        logic frozen;
        logic k_last;
        logic epoch_end;
        logic div_done;
        logic out_free;
    } t_stat;

    function automatic logic [15:0] sig_val(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:  v = 16'd32768;
            5'd1:  v = 16'd40793;
            5'd2:  v = 16'd47911;
            5'd3:  v = 16'd53581;
            5'd4:  v = 16'd57724;
            5'd5:  v = 16'd60565;
            5'd6:  v = 16'd62428;
            5'd7:  v = 16'd63615;
            5'd8:  v = 16'd64357;
            5'd9:  v = 16'd64816;
            5'd10: v = 16'd65097;
            5'd11: v = 16'd65269;
            5'd12: v = 16'd65374;
            5'd13: v = 16'd65438;
            5'd14: v = 16'd65476;
            5'd15: v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] ln_val(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd3973;
            5'd2:  v = 16'd7719;
            5'd3:  v = 16'd11262;
            5'd4:  v = 16'd14624;
            5'd5:  v = 16'd17821;
            5'd6:  v = 16'd20870;
            5'd7:  v = 16'd23783;
            5'd8:  v = 16'd26573;
            5'd9:  v = 16'd29248;
            5'd10: v = 16'd31818;
            5'd11: v = 16'd34292;
            5'd12: v = 16'd36675;
            5'd13: v = 16'd38975;
            5'd14: v = 16'd41196;
            5'd15: v = 16'd43345;
            default: v = 16'd45426;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/lrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module lrt_div #(
    parameter int DIVISOR_W = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lrt_pkg::ACC_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]      i_divisor,
    output logic                      o_done,
    output logic [lrt_pkg::ACC_W-1:0] o_quot
);
    import lrt_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_d;
    logic [ACC_W-1:0]    r_quot;
    logic [DIVISOR_W:0]  trial;
    logic                qbit;
    logic [DIVISOR_W:0]  rem_next;

    always_comb begin
        trial    = {r_rem, r_quot[ACC_W-1]};
        qbit     = trial >= {1'b0, r_d};
        rem_next = qbit ? trial - {1'b0, r_d} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_d    <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= rem_next[DIVISOR_W-1:0];
            r_quot <= {r_quot[ACC_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/lrt_dp.sv =====
// Datapath: sample store, shared multiplier, sigmoid and log tables, accumulators, weights.
module lrt_dp #(
    parameter int NUM_FEATURES = 8,
    parameter int FRAC_BITS    = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lrt_pkg::t_cmd             i_cmd,
    output lrt_pkg::t_stat            o_stat,
    input  lrt_pkg::t_vec             i_x,
    input  logic                      i_label,
    input  logic                      i_epoch_end,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [lrt_pkg::LR_W-1:0]  i_cfg_data,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output lrt_pkg::t_vec             o_w,
    output logic [30:0]               o_mean,
    output logic [15:0]               o_epoch
);
    import lrt_pkg::*;

    localparam int SH_DN = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [64:0] W_MAX = 65'sd2147483647;
    localparam logic signed [64:0] W_MIN = -65'sd2147483648;
    localparam logic signed [64:0] G_MAX = 65'sh007FFFFFFFFFFFFF;
    localparam logic signed [64:0] G_MIN = -65'sh0080000000000000;

    logic [IDX_W-1:0]            r_k;
    logic [FEAT_W-1:0]           r_x [NFEAT_MAX];
    logic                        r_label;
    logic                        r_eoe;
    logic signed [FEAT_W-1:0]    r_w [NFEAT_MAX];
    logic signed [ACC_W-1:0]     r_g [NFEAT_MAX];
    logic [ACC_W-1:0]            r_cost;
    logic [COUNT_BITS-1:0]       r_count;
    logic [LIM_W-1:0]            r_epochs;
    logic [LR_W-1:0]             r_lr;
    logic [LIM_W-1:0]            r_limit;
    logic signed [63:0]          r_prod;
    logic signed [63:0]          r_z;
    logic [16:0]                 r_h;
    logic [39:0]                 r_cq;
    logic signed [17:0]          r_err;
    logic signed [31:0]          r_mg;
    logic [30:0]                 r_mean;
    logic                        r_out_valid;
    t_vec                        r_out_w;
    logic [30:0]                 r_out_mean;
    logic [15:0]                 r_out_epoch;

    logic signed [31:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic [63:0]         z_abs;
    logic [19:0]         a16;
    logic [4:0]          si;
    logic [15:0]         s_val;
    logic [16:0]         h_val;
    logic [15:0]         p;
    logic [3:0]          e;
    logic [15:0]         q;
    logic [4:0]          li;
    logic [15:0]         l_val;
    logic [19:0]         c16;
    logic [39:0]         cq;
    logic [ACC_W:0]      cost_sum;
    logic signed [64:0]  g_sum;
    logic [ACC_W-1:0]    g_mag;
    logic [ACC_W-1:0]    div_dividend;
    logic                div_start;
    logic                div_done;
    logic [ACC_W-1:0]    div_quot;
    logic signed [31:0]  mg;
    logic signed [64:0]  w_diff;

    always_comb begin
        case (i_cmd.op)
            OP_GRAD_MUL: begin
                mul_a = 32'(r_err);
                mul_b = $signed(r_x[r_k]);
            end
            OP_UPD_MUL: begin
                mul_a = $signed({1'b0, r_lr});
                mul_b = r_mg;
            end
            default: begin
                mul_a = r_w[r_k];
                mul_b = $signed(r_x[r_k]);
            end
        endcase
    end

    always_comb begin
        z_abs = r_z[63] ? 64'(-r_z) : 64'(r_z);
        if (z_abs >= (64'd8 << FRAC_BITS))
            a16 = 20'h80000;
        else if (FRAC_BITS >= 16)
            a16 = 20'(z_abs >> SH_DN);
        else
            a16 = 20'(z_abs << SH_UP);
        si = a16[19:15];
        if (si >= 5'd16)
            s_val = sig_val(5'd16);
        else
            s_val = sig_val(si) + 16'(((32'(sig_val(5'(si + 1'b1))) - 32'(sig_val(si)))
                    * 32'(a16[14:0])) >> 15);
        h_val = r_z[63] ? 17'd65536 - 17'(s_val) : 17'(s_val);
    end

    always_comb begin
        p = r_label ? r_h[15:0] : 16'(17'd65536 - r_h);
        if (p == 16'd0)
            p = 16'd1;
        e = 4'd0;
        for (int j = 1; j < 16; j++) begin
            if (p[j])
                e = 4'(j);
        end
        q     = p << (4'd15 - e);
        li    = {1'b0, q[14:11]};
        l_val = ln_val(li) + 16'(((32'(ln_val(5'(li + 1'b1))) - 32'(ln_val(li)))
                * 32'(q[10:0])) >> 11);
        c16   = 20'(5'd16 - 5'(e)) * LN2_Q16 - 20'(l_val);
        if (FRAC_BITS >= 16)
            cq = 40'(c16) << SH_DN;
        else
            cq = 40'(c16) >> SH_UP;
    end

    always_comb begin
        cost_sum = {1'b0, r_cost} + (ACC_W + 1)'(r_cq);
        g_sum    = 65'(r_g[r_k]) + 65'(r_prod >>> 16);
        g_mag    = r_g[r_k][ACC_W-1] ? ACC_W'(-r_g[r_k]) : ACC_W'(r_g[r_k]);
        if (r_g[r_k][ACC_W-1])
            mg = (div_quot > ACC_W'(64'h80000000)) ? 32'sh80000000 : 32'(-div_quot);
        else
            mg = (div_quot > ACC_W'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : 32'(div_quot);
        w_diff = 65'(r_w[r_k]) - 65'(r_prod >>> FRAC_BITS);
        div_start    = (i_cmd.op == OP_DIV_GO) || (i_cmd.op == OP_MEAN_GO);
        div_dividend = (i_cmd.op == OP_MEAN_GO) ? r_cost : g_mag;
    end

    lrt_div #(
        .DIVISOR_W (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_cost      <= '0;
            r_count     <= '0;
            r_epochs    <= '0;
            r_lr        <= LR_RESET;
            r_limit     <= LIM_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NFEAT_MAX; k++) begin
                r_w[k] <= '0;
                r_g[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LR:    r_lr    <= i_cfg_data;
                    CFG_LIMIT: r_limit <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.k_clr)
                r_k <= '0;
            else if (i_cmd.k_inc)
                r_k <= r_k + 1'b1;
            if (i_cmd.op == OP_LOAD)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_COST: begin
                    r_cost <= cost_sum[ACC_W] ? '1 : cost_sum[ACC_W-1:0];
                    if (r_count != '1)
                        r_count <= r_count + 1'b1;
                end
                OP_GRAD_ACC: begin
                    if (g_sum > G_MAX)
                        r_g[r_k] <= ACC_W'(G_MAX);
                    else if (g_sum < G_MIN)
                        r_g[r_k] <= ACC_W'(G_MIN);
                    else
                        r_g[r_k] <= ACC_W'(g_sum);
                end
                OP_UPD_ACC: begin
                    if (w_diff > W_MAX)
                        r_w[r_k] <= 32'(W_MAX);
                    else if (w_diff < W_MIN)
                        r_w[r_k] <= 32'(W_MIN);
                    else
                        r_w[r_k] <= 32'(w_diff);
                end
                OP_LOAD: begin
                    r_epochs    <= r_epochs + 1'b1;
                    r_cost      <= '0;
                    r_count     <= '0;
                    for (int k = 0; k < NFEAT_MAX; k++)
                        r_g[k] <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                for (int k = 0; k < NFEAT_MAX; k++)
                    r_x[k] <= i_x[k];
                r_label <= i_label;
                r_eoe   <= i_epoch_end;
                r_z     <= '0;
            end
            OP_DOT_MUL, OP_GRAD_MUL, OP_UPD_MUL: r_prod <= mul_a * mul_b;
            OP_DOT_ACC: r_z <= r_z + (r_prod >>> FRAC_BITS);
            OP_SIG:     r_h <= h_val;
            OP_LOG: begin
                r_cq  <= cq;
                r_err <= $signed({1'b0, r_h}) - $signed({1'b0, r_label, 16'd0});
            end
            OP_DIV_WAIT: begin
                if (div_done)
                    r_mg <= mg;
            end
            OP_MEAN_WAIT: begin
                if (div_done)
                    r_mean <= (div_quot > ACC_W'(64'h7FFFFFFF)) ? '1 : div_quot[30:0];
            end
            OP_LOAD: begin
                for (int k = 0; k < NFEAT_MAX; k++)
                    r_out_w[k] <= r_w[k];
                r_out_mean  <= r_mean;
                r_out_epoch <= r_epochs + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.frozen    = r_epochs >= r_limit;
        o_stat.k_last    = r_k == IDX_W'(NUM_FEATURES - 1);
        o_stat.epoch_end = r_eoe;
        o_stat.div_done  = div_done;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_w         = r_out_w;
    assign o_mean      = r_out_mean;
    assign o_epoch     = r_out_epoch;

`ifndef NO_ASSERTIONS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_count != '0)
        else $error("divide started with zero sample count");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD) |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over one not yet taken");
    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.op == OP_LOAD))
        else $error("result valid without a load");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.k_inc && !i_cmd.k_clr |-> !o_stat.k_last)
        else $error("feature index stepped past the last feature");
`endif

endmodule

// ===== rtl/lrt_ctrl.sv =====
// Controller: sequences one sample and the end-of-epoch weight update.
module lrt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lrt_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output lrt_pkg::t_cmd  o_cmd
);
    import lrt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_stat.frozen)
                    n_state = S_DOT_MUL;
            end
            S_DOT_MUL:  n_state = S_DOT_ACC;
            S_DOT_ACC:  n_state = i_stat.k_last ? S_SIG : S_DOT_MUL;
            S_SIG:      n_state = S_LOG;
            S_LOG:      n_state = S_COST;
            S_COST:     n_state = S_GRAD_MUL;
            S_GRAD_MUL: n_state = S_GRAD_ACC;
            S_GRAD_ACC: begin
                if (!i_stat.k_last)
                    n_state = S_GRAD_MUL;
                else
                    n_state = i_stat.epoch_end ? S_DIV_GO : S_IDLE;
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_stat.div_done)
                    n_state = S_UPD_MUL;
            end
            S_UPD_MUL:  n_state = S_UPD_ACC;
            S_UPD_ACC:  n_state = i_stat.k_last ? S_MEAN_GO : S_DIV_GO;
            S_MEAN_GO:  n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: begin
                if (i_stat.div_done)
                    n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free)
                    n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.k_clr = 1'b0;
        o_cmd.k_inc = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !i_stat.frozen) begin
                    o_cmd.op    = OP_CAPTURE;
                    o_cmd.k_clr = 1'b1;
                end
            end
            S_DOT_MUL:  o_cmd.op = OP_DOT_MUL;
            S_DOT_ACC: begin
                o_cmd.op    = OP_DOT_ACC;
                o_cmd.k_inc = !i_stat.k_last;
                o_cmd.k_clr = i_stat.k_last;
            end
            S_SIG:      o_cmd.op = OP_SIG;
            S_LOG:      o_cmd.op = OP_LOG;
            S_COST:     o_cmd.op = OP_COST;
            S_GRAD_MUL: o_cmd.op = OP_GRAD_MUL;
            S_GRAD_ACC: begin
                o_cmd.op    = OP_GRAD_ACC;
                o_cmd.k_inc = !i_stat.k_last;
                o_cmd.k_clr = i_stat.k_last;
            end
            S_DIV_GO:   o_cmd.op = OP_DIV_GO;
            S_DIV_WAIT: o_cmd.op = OP_DIV_WAIT;
            S_UPD_MUL:  o_cmd.op = OP_UPD_MUL;
            S_UPD_ACC: begin
                o_cmd.op    = OP_UPD_ACC;
                o_cmd.k_inc = !i_stat.k_last;
                o_cmd.k_clr = i_stat.k_last;
            end
            S_MEAN_GO:   o_cmd.op = OP_MEAN_GO;
            S_MEAN_WAIT: o_cmd.op = OP_MEAN_WAIT;
            S_LOAD: begin
                if (i_stat.out_free)
                    o_cmd.op = OP_LOAD;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/logistic_regression_trainer.sv =====
// Top level of the logistic regression trainer: stream ports, controller and datapath.
// A sample runs a multiply and accumulate per feature for the dot product, the sigmoid, log and
// cost steps, and a gradient step per feature before the next ready. The last sample of an epoch
// adds the 56-step divider per weight and for the mean cost, plus the shared 32x32 multiplier step of each update.
// A result waits in the output register while the next sample is taken.
// Synchronous reset clears weights, accumulators, counters and restores register defaults.
module logistic_regression_trainer #(
    parameter int NUM_FEATURES = 8,
    parameter int FRAC_BITS    = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [255:0]  s_axis_tdata,  // feature_0 .. feature_7
    input  logic          s_axis_tuser,  // label
    input  logic          s_axis_tlast,  // epoch_end
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [303:0]  m_axis_tdata,  // weight_0 .. weight_7, mean_cost, epoch_number, pad
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [30:0]   i_cfg_data
);
    import lrt_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_vec  x_vec;
    t_vec  w_vec;
    logic [30:0] mean;
    logic [15:0] epoch;

    assign x_vec = s_axis_tdata;

    lrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    lrt_dp #(
        .NUM_FEATURES (NUM_FEATURES),
        .FRAC_BITS    (FRAC_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_x         (x_vec),
        .i_label     (s_axis_tuser),
        .i_epoch_end (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_w         (w_vec),
        .o_mean      (mean),
        .o_epoch     (epoch)
    );

    assign m_axis_tdata = {1'b0, epoch, mean, w_vec};

endmodule

// ===== tb/tb_logistic_regression_trainer.sv =====
// Self-checking testbench for the logistic regression trainer, with a directed table and random epochs.
`timescale 1ns / 100ps

module tb_logistic_regression_trainer;
    import lrt_pkg::*;

    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  SETTLE       = 700;
    localparam int  HOLD_CYCLES  = 3000;
    localparam int  HOLD_AT      = 20;
    localparam int  LN2          = 45426;
    localparam int  DUE_DEPTH    = 64;
    localparam longint GSUM_MAX  = 64'sh007F_FFFF_FFFF_FFFF;
    localparam longint GSUM_MIN  = -GSUM_MAX - 1;
    localparam longint CSUM_MAX  = 64'sh00FF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [15:0]      epoch;
        logic [30:0]      cost;
        logic [7:0][31:0] w;
    } t_epoch_res;

    typedef struct {
        logic [31:0] fa;
        logic [31:0] fb;
        logic        label;
        logic        last;
        logic        typed;
        logic [30:0] cost;
        logic [15:0] epoch;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;   // feature_0 .. feature_7
    logic         s_axis_tuser = 1'b0; // label
    logic         s_axis_tlast = 1'b0; // epoch_end
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [303:0] m_axis_tdata;        // weight_0 .. weight_7, mean_cost, epoch_number, pad
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [30:0]  i_cfg_data = '0;

    int         sig_tab [17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
                                 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
                                 65514};
    int         ln_tab [17]  = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
                                 29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

    longint     m_rate, m_limit, m_w [8], m_gsum [8], m_epochs;
    longint unsigned m_csum, m_count;
    t_epoch_res epochs_due [DUE_DEPTH];
    int         due_wr = 0;
    int         due_rd = 0;
    int         errors = 0;
    int         cycles = 0;
    int         results_seen = 0;

    logistic_regression_trainer uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sigmoid(longint z);
        longint a, i, fr, s;
        a = z < 0 ? -z : z;
        if (a >= (64'sd8 << 16))
            a = 64'sd8 << 16;
        i  = a >> 15;
        fr = a & 32767;
        if (i >= 16)
            s = sig_tab[16];
        else
            s = sig_tab[i] + (((sig_tab[i+1] - sig_tab[i]) * fr) >> 15);
        return z < 0 ? 65536 - s : s;
    endfunction

    function automatic longint neg_log(longint p);
        longint e, f, i, fr, l;
        e = 0;
        while (e < 15 && (p >> (e + 1)) != 0)
            e++;
        f  = (p << (15 - e)) - 32768;
        i  = f >> 11;
        fr = f & 2047;
        l  = ln_tab[i] + (((ln_tab[i+1] - ln_tab[i]) * fr) >> 11);
        return (16 - e) * LN2 - l;
    endfunction

    task automatic reset_model();
        m_rate = 6554;
        m_limit = 10;
        m_csum = 0;
        m_count = 0;
        m_epochs = 0;
        for (int k = 0; k < 8; k++) begin
            m_w[k] = 0;
            m_gsum[k] = 0;
        end
    endtask

    // Advance the model by one sample; sets got to 1 with the epoch result on an epoch end.
    task automatic train_sample(input logic [255:0] feat, input logic label, input logic last,
                                output bit got, output t_epoch_res res);
        longint x [8];
        longint z, h, err, mag, mg, mean;
        got = 0;
        res = '0;
        if (m_epochs >= m_limit)
            return;
        z = 0;
        for (int k = 0; k < 8; k++) begin
            x[k] = longint'($signed(feat[k*32 +: 32]));
            z += (m_w[k] * x[k]) >>> 16;
        end
        h = sigmoid(z);
        m_csum += neg_log(label ? h : 65536 - h);
        if (m_csum > CSUM_MAX)
            m_csum = CSUM_MAX;
        err = h - (longint'(label) << 16);
        for (int k = 0; k < 8; k++)
            m_gsum[k] = sat(m_gsum[k] + ((err * x[k]) >>> 16), GSUM_MIN, GSUM_MAX);
        if (m_count < 65535)
            m_count++;
        if (!last)
            return;
        for (int k = 0; k < 8; k++) begin
            mag = m_gsum[k] < 0 ? -m_gsum[k] : m_gsum[k];
            mg  = mag / longint'(m_count);
            if (m_gsum[k] < 0)
                mg = -mg;
            mg = sat(mg, -64'sd2147483648, 64'sd2147483647);
            m_w[k] = sat(m_w[k] - ((m_rate * mg) >>> 16), -64'sd2147483648, 64'sd2147483647);
            res.w[k] = m_w[k][31:0];
            m_gsum[k] = 0;
        end
        mean = longint'(m_csum / m_count);
        res.cost = mean > 64'sh7FFF_FFFF ? 31'h7FFF_FFFF : mean[30:0];
        m_epochs++;
        res.epoch = m_epochs[15:0];
        m_csum = 0;
        m_count = 0;
        got = 1;
    endtask

    task automatic send_sample(input logic [255:0] feat, input logic label, input logic last,
                               input bit typed, input t_epoch_res typed_res);
        int gap;
        bit got;
        t_epoch_res res;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= feat;
        s_axis_tuser  <= label;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        train_sample(feat, label, last, got, res);
        if (got) begin
            epochs_due[due_wr % DUE_DEPTH] = typed ? typed_res : res;
            due_wr++;
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        wait (due_wr == due_rd);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_LR)
            m_rate = val;
        else
            m_limit = val[15:0];
    endtask

    function automatic logic [31:0] rand_feature();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    endfunction

    task automatic random_epochs(input int n_items);
        logic [255:0] feat;
        int left;
        logic last;
        left = $urandom_range(1, 12);
        for (int n = 0; n < n_items; n++) begin
            for (int k = 0; k < 8; k++)
                feat[k*32 +: 32] = rand_feature();
            left--;
            last = (left == 0) || ($urandom_range(0, 19) == 0);
            if (last)
                left = $urandom_range(1, 12);
            send_sample(feat, 1'($urandom), last, 0, '0);
        end
    endtask

    // Output side: random stalls per result, one long hold-off to back the block up.
    initial begin
        t_epoch_res got, want;
        int gap;
        forever begin
            gap = (results_seen == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, 4);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            results_seen++;
            got = m_axis_tdata[302:0];
            if (due_wr == due_rd) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = epochs_due[due_rd % DUE_DEPTH];
                due_rd++;
                for (int k = 0; k < 8; k++)
                    if (got.w[k] !== want.w[k]) begin
                        $display("%0t: weight_%0d expected %h actual %h",
                                 $time, k, want.w[k], got.w[k]);
                        errors++;
                    end
                if (got.cost !== want.cost) begin
                    $display("%0t: mean_cost expected %h actual %h", $time, want.cost, got.cost);
                    errors++;
                end
                if (got.epoch !== want.epoch) begin
                    $display("%0t: epoch_number expected %0d actual %0d",
                             $time, want.epoch, got.epoch);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row       dir_tab [16];
        t_epoch_res typed_res;
        logic [255:0] feat;
        dir_tab = '{
            '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 31'd45426, 16'd1},
            '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 31'd45426, 16'd2},
            '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 31'd0, 16'd0},
            '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 31'd0, 16'd0},
            '{32'h0001_0000, 32'hFFFE_0000, 1'b1, 1'b0, 1'b0, 31'd0, 16'd0},
            '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 31'd0, 16'd0},
            '{32'h0008_0000, 32'hFFF8_0000, 1'b1, 1'b1, 1'b0, 31'd0, 16'd0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 31'd0, 16'd0},
            '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 1'b0, 31'd0, 16'd0},
            '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 31'd0, 16'd0},
            '{32'h1234_5678, 32'hEDCB_A987, 1'b1, 1'b1, 1'b0, 31'd0, 16'd0},
            '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 31'd0, 16'd0},
            '{32'h0000_4000, 32'hFFFF_C000, 1'b0, 1'b1, 1'b0, 31'd0, 16'd0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0, 31'd0, 16'd0},
            '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 31'd0, 16'd0},
            '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 31'd0, 16'd0}
        };
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            for (int k = 0; k < 8; k++)
                feat[k*32 +: 32] = k[0] ? dir_tab[r].fb : dir_tab[r].fa;
            typed_res = '{w: '0, cost: dir_tab[r].cost, epoch: dir_tab[r].epoch};
            send_sample(feat, dir_tab[r].label, dir_tab[r].last, dir_tab[r].typed, typed_res);
        end
        settle();

        write_reg(CFG_LIMIT, 31'd0);
        random_epochs(5);
        settle();
        write_reg(CFG_LIMIT, 31'd65535);
        write_reg(CFG_LR, 31'd0);
        random_epochs(150);
        settle();
        write_reg(CFG_LR, 31'h7FFF_FFFF);
        random_epochs(150);
        settle();
        write_reg(CFG_LR, 31'd6554);
        random_epochs(400);
        settle();
        write_reg(CFG_LR, 31'($urandom_range(1, 20000)));
        write_reg(CFG_LIMIT, 31'(m_epochs + 5));
        random_epochs(400);
        settle();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
